// File: hdl/assert_macros.svh
// Assertion macros shared by the statistics unit.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Overlapping implication, checked at every rising clock edge outside reset.
`define RLS_ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// Implication whose consequent is checked in the cycle after the antecedent.
`define RLS_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

// File: hdl/rls_pkg.sv
// Package: constants and controller/datapath interface types of the statistics unit.
package rls_pkg;

   localparam int RLS_TIME_BITS  = 32;
   localparam int RLS_FIELD_BITS = 32;
   localparam int RLS_COUNT_BITS = 32;
   localparam logic [RLS_COUNT_BITS-1:0] RLS_COUNT_MAX = 32'hFFFF_FFFF;

   // Operation codes of the input item.
   localparam logic RLS_OP_ADD   = 1'b0;
   localparam logic RLS_OP_CLEAR = 1'b1;

   typedef struct packed {
      logic load_inputs;
      logic update;
      logic div_step;
      logic load_out;
   } rls_cmd_type;

   typedef struct packed {
      logic is_clear;
      logic div_last;
   } rls_status_type;

endpackage

// File: hdl/runtime_latency_statistics_unit.sv
// Top level of the runtime latency statistics unit: controller, datapath and checks.
// Each item either adds one sample, whose duration is the end stamp minus the begin stamp
// modulo 2^TIME_BITS, or clears the statistics (operation 1). For every item one result
// comes back carrying the statistics after that item: saturating sample count, wrapping total
// with a sticky overflow flag, best, worst and last durations and the truncated average
// total / count. An add item goes through these steps from acceptance until the next
// item can be accepted: capture the duration, update the statistics, run the
// one-bit-per-cycle restoring divider that forms the average, and load the result
// register once it is free. A clear item skips the divider. One item is in work at a
// time; the result register lets a new item be accepted while the previous result
// still waits to be taken. With TIME_BITS above 32 the statistics are kept at full
// width and the result fields carry their low 32 bits.
`include "assert_macros.svh"

module runtime_latency_statistics_unit
   import rls_pkg::*;
#(
   parameter int TIME_BITS = RLS_TIME_BITS
)(
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_stall,
   input  logic                      req_operation,
   input  logic [RLS_FIELD_BITS-1:0] req_begin_stamp,
   input  logic [RLS_FIELD_BITS-1:0] req_end_stamp,
   output logic                      rsp_valid,
   input  logic                      rsp_stall,
   output logic [RLS_FIELD_BITS-1:0] rsp_sample_count,
   output logic [RLS_FIELD_BITS-1:0] rsp_total_time,
   output logic [RLS_FIELD_BITS-1:0] rsp_average_time,
   output logic [RLS_FIELD_BITS-1:0] rsp_worst_time,
   output logic [RLS_FIELD_BITS-1:0] rsp_best_time,
   output logic [RLS_FIELD_BITS-1:0] rsp_last_time,
   output logic                      rsp_total_overflow
);

   rls_cmd_type    cmd;
   rls_status_type status;

   // The controller owns the handshakes and steps the datapath through its phases.
   rls_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .cmd       (cmd),
      .status    (status)
   );

   // The datapath holds the statistics, the divider and the result register.
   rls_dp #(
      .TIME_BITS (TIME_BITS)
   ) u_dp (
      .clock              (clock),
      .reset              (reset),
      .cmd                (cmd),
      .status             (status),
      .req_operation      (req_operation),
      .req_begin_stamp    (req_begin_stamp),
      .req_end_stamp      (req_end_stamp),
      .rsp_sample_count   (rsp_sample_count),
      .rsp_total_time     (rsp_total_time),
      .rsp_average_time   (rsp_average_time),
      .rsp_worst_time     (rsp_worst_time),
      .rsp_best_time      (rsp_best_time),
      .rsp_last_time      (rsp_last_time),
      .rsp_total_overflow (rsp_total_overflow)
   );

   // Once an item is taken the block is busy in the following cycle.
   `RLS_ASSERT_NEXT(a_busy_after_accept, clock, reset, req_valid && !req_stall, req_stall)
   // A new result appears only as the block returns to accepting items.
   `RLS_ASSERT_SAME(a_result_when_idle, clock, reset, $rose(rsp_valid), !req_stall)
   // With no samples since a clear, total and average are both zero.
   `RLS_ASSERT_SAME(a_empty_stats, clock, reset, rsp_valid && (rsp_sample_count == '0),
      (rsp_total_time == '0) && (rsp_average_time == '0))

endmodule

// File: hdl/rls_ctrl.sv
// Controller state machine that sequences update, division and result delivery.
module rls_ctrl
   import rls_pkg::*;
(
   input  logic           clock,
   input  logic           reset,
   input  logic           req_valid,
   output logic           req_stall,
   output logic           rsp_valid,
   input  logic           rsp_stall,
   output rls_cmd_type    cmd,
   input  rls_status_type status
);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_UPDATE,
      ST_DIVIDE,
      ST_FINISH
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      out_free;

   // The result register can take a new item when empty or being drained.
   assign out_free = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      state_in     = state_ff;
      cmd          = '0;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.load_inputs = 1'b1;
               state_in        = ST_UPDATE;
            end
         end
         ST_UPDATE: begin
            cmd.update = 1'b1;
            state_in   = status.is_clear ? ST_FINISH : ST_DIVIDE;
         end
         ST_DIVIDE: begin
            cmd.div_step = 1'b1;
            if (status.div_last) begin
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            if (out_free) begin
               cmd.load_out = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

endmodule

// File: hdl/rls_dp.sv
// Datapath: statistics registers, restoring divider and result register.
module rls_dp
   import rls_pkg::*;
#(
   parameter int TIME_BITS = RLS_TIME_BITS
)(
   input  logic                      clock,
   input  logic                      reset,
   input  rls_cmd_type               cmd,
   output rls_status_type            status,
   input  logic                      req_operation,
   input  logic [RLS_FIELD_BITS-1:0] req_begin_stamp,
   input  logic [RLS_FIELD_BITS-1:0] req_end_stamp,
   output logic [RLS_FIELD_BITS-1:0] rsp_sample_count,
   output logic [RLS_FIELD_BITS-1:0] rsp_total_time,
   output logic [RLS_FIELD_BITS-1:0] rsp_average_time,
   output logic [RLS_FIELD_BITS-1:0] rsp_worst_time,
   output logic [RLS_FIELD_BITS-1:0] rsp_best_time,
   output logic [RLS_FIELD_BITS-1:0] rsp_last_time,
   output logic                      rsp_total_overflow
);

   localparam int StepBits = $clog2(TIME_BITS);

   logic                      op_ff;
   logic [TIME_BITS-1:0]      dur_ff;
   logic [RLS_COUNT_BITS-1:0] count_ff;
   logic [TIME_BITS-1:0]      total_ff, worst_ff, best_ff, last_ff;
   logic                      ovf_ff;
   logic [TIME_BITS-1:0]      quo_ff, quo_in;
   logic [RLS_COUNT_BITS-1:0] rem_ff, rem_in;
   logic [StepBits-1:0]       step_ff;

   logic [TIME_BITS:0]        sum;
   logic [RLS_COUNT_BITS:0]   rem_shift, diff;

   assign sum = {1'b0, total_ff} + {1'b0, dur_ff};

   // One restoring division step: shift in the next dividend bit, try to subtract.
   assign rem_shift = {rem_ff, quo_ff[TIME_BITS-1]};
   assign diff      = rem_shift - {1'b0, count_ff};

   always_comb begin
      if (!diff[RLS_COUNT_BITS]) begin
         rem_in = diff[RLS_COUNT_BITS-1:0];
         quo_in = {quo_ff[TIME_BITS-2:0], 1'b1};
      end else begin
         rem_in = rem_shift[RLS_COUNT_BITS-1:0];
         quo_in = {quo_ff[TIME_BITS-2:0], 1'b0};
      end
   end

   // Statistics state; the quotient register doubles as the average.
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         total_ff <= '0;
         worst_ff <= '0;
         best_ff  <= '1;
         last_ff  <= '0;
         ovf_ff   <= 1'b0;
         quo_ff   <= '0;
      end else if (cmd.update) begin
         if (op_ff == RLS_OP_CLEAR) begin
            count_ff <= '0;
            total_ff <= '0;
            worst_ff <= '0;
            best_ff  <= '1;
            last_ff  <= '0;
            ovf_ff   <= 1'b0;
            quo_ff   <= '0;
         end else begin
            if (count_ff != RLS_COUNT_MAX) begin
               count_ff <= count_ff + 1'b1;
            end
            last_ff <= dur_ff;
            if (dur_ff < best_ff) begin
               best_ff <= dur_ff;
            end
            if (dur_ff > worst_ff) begin
               worst_ff <= dur_ff;
            end
            total_ff <= sum[TIME_BITS-1:0];
            if (sum[TIME_BITS]) begin
               ovf_ff <= 1'b1;
            end
            quo_ff <= sum[TIME_BITS-1:0];
         end
      end else if (cmd.div_step) begin
         quo_ff <= quo_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_inputs) begin
         op_ff  <= req_operation;
         dur_ff <= TIME_BITS'(req_end_stamp) - TIME_BITS'(req_begin_stamp);
      end
      if (cmd.update) begin
         rem_ff  <= '0;
         step_ff <= StepBits'(TIME_BITS - 1);
      end else if (cmd.div_step) begin
         rem_ff  <= rem_in;
         step_ff <= step_ff - 1'b1;
      end
      if (cmd.load_out) begin
         rsp_sample_count   <= count_ff;
         rsp_total_time     <= RLS_FIELD_BITS'(total_ff);
         rsp_average_time   <= RLS_FIELD_BITS'(quo_ff);
         rsp_worst_time     <= RLS_FIELD_BITS'(worst_ff);
         rsp_best_time      <= RLS_FIELD_BITS'(best_ff);
         rsp_last_time      <= RLS_FIELD_BITS'(last_ff);
         rsp_total_overflow <= ovf_ff;
      end
   end

   assign status.is_clear = (op_ff == RLS_OP_CLEAR);
   assign status.div_last = (step_ff == '0);

endmodule

// File: sim/testbench.sv
// Self-checking testbench for the runtime latency statistics unit, with a scoreboard class.
module testbench
   import rls_pkg::*;
();

   timeunit 1ns;
   timeprecision 1ps;

   // Statistics carried by one result item, in port order.
   typedef struct packed {
      logic [RLS_FIELD_BITS-1:0] sample_count;
      logic [RLS_FIELD_BITS-1:0] total_time;
      logic [RLS_FIELD_BITS-1:0] average_time;
      logic [RLS_FIELD_BITS-1:0] worst_time;
      logic [RLS_FIELD_BITS-1:0] best_time;
      logic [RLS_FIELD_BITS-1:0] last_time;
      logic                      total_overflow;
   } latency_stats_type;

   // The scoreboard keeps its own copy of the statistics. Every accepted input item
   // advances that copy and queues the statistics the block should report for it; every
   // accepted result item is compared with the oldest queued statistics.
   class latency_scoreboard;
      latency_stats_type expected_stats_q[$];
      logic [RLS_TIME_BITS-1:0] count_acc;
      logic [RLS_TIME_BITS-1:0] total_acc;
      logic [RLS_TIME_BITS-1:0] average_acc;
      logic [RLS_TIME_BITS-1:0] worst_acc;
      logic [RLS_TIME_BITS-1:0] best_acc;
      logic [RLS_TIME_BITS-1:0] last_acc;
      logic                     overflow_acc;
      int errors;
      int results_checked;
      int clears_seen;
      int overflow_results;

      function new();
         clear_stats();
         errors = 0;
         results_checked = 0;
         clears_seen = 0;
         overflow_results = 0;
      endfunction

      // Same state as after reset: best starts at all ones so the first sample wins.
      function void clear_stats();
         count_acc    = '0;
         total_acc    = '0;
         average_acc  = '0;
         worst_acc    = '0;
         best_acc     = '1;
         last_acc     = '0;
         overflow_acc = 1'b0;
      endfunction

      function void note_item(logic op, logic [31:0] start_t, logic [31:0] stop_t);
         logic [RLS_TIME_BITS-1:0] duration;
         logic [RLS_TIME_BITS-1:0] sum;
         latency_stats_type stats;
         if (op == RLS_OP_CLEAR) begin
            clear_stats();
            clears_seen++;
         end else begin
            // Modular subtraction handles an interval that spans a timer wrap.
            duration = stop_t - start_t;
            if (count_acc != RLS_COUNT_MAX) count_acc = count_acc + 1'b1;
            last_acc = duration;
            if (duration < best_acc) best_acc = duration;
            if (duration > worst_acc) worst_acc = duration;
            sum = total_acc + duration;
            if (sum < total_acc) overflow_acc = 1'b1;
            total_acc = sum;
            average_acc = (count_acc != 0) ? total_acc / count_acc : '0;
         end
         stats.sample_count   = count_acc;
         stats.total_time     = total_acc;
         stats.average_time   = average_acc;
         stats.worst_time     = worst_acc;
         stats.best_time      = best_acc;
         stats.last_time      = last_acc;
         stats.total_overflow = overflow_acc;
         expected_stats_q.push_back(stats);
      endfunction

      function void compare_field(string name, logic [31:0] want, logic [31:0] got);
         if (want !== got) begin
            $display("%0d ns: %s mismatch, expected %h, actual %h", $time, name, want, got);
            errors++;
         end
      endfunction

      function void check_result(latency_stats_type got);
         latency_stats_type want;
         if (expected_stats_q.size() == 0) begin
            $display("%0d ns: result item with nothing expected, actual %h", $time, got);
            errors++;
         end else begin
            want = expected_stats_q.pop_front();
            results_checked++;
            if (want.total_overflow) overflow_results++;
            compare_field("sample_count", want.sample_count, got.sample_count);
            compare_field("total_time", want.total_time, got.total_time);
            compare_field("average_time", want.average_time, got.average_time);
            compare_field("worst_time", want.worst_time, got.worst_time);
            compare_field("best_time", want.best_time, got.best_time);
            compare_field("last_time", want.last_time, got.last_time);
            compare_field("total_overflow", {31'b0, want.total_overflow},
                          {31'b0, got.total_overflow});
         end
      endfunction

      function int pending();
         return expected_stats_q.size();
      endfunction
   endclass

   logic                      clock;
   logic                      reset;
   logic                      req_valid;
   logic                      req_stall;
   logic                      req_operation;
   logic [RLS_FIELD_BITS-1:0] req_begin_stamp;
   logic [RLS_FIELD_BITS-1:0] req_end_stamp;
   logic                      rsp_valid;
   logic                      rsp_stall;
   logic [RLS_FIELD_BITS-1:0] rsp_sample_count;
   logic [RLS_FIELD_BITS-1:0] rsp_total_time;
   logic [RLS_FIELD_BITS-1:0] rsp_average_time;
   logic [RLS_FIELD_BITS-1:0] rsp_worst_time;
   logic [RLS_FIELD_BITS-1:0] rsp_best_time;
   logic [RLS_FIELD_BITS-1:0] rsp_last_time;
   logic                      rsp_total_overflow;

   // Percentages of idle sender cycles and stalled receiver cycles for the current phase.
   int  send_idle_pct;
   int  rsp_stall_pct;
   // High while the receiver holds off on purpose for a long stretch.
   logic hold_off;
   int  items_sent;

   latency_scoreboard stats_board;

   runtime_latency_statistics_unit dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_operation      (req_operation),
      .req_begin_stamp    (req_begin_stamp),
      .req_end_stamp      (req_end_stamp),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_sample_count   (rsp_sample_count),
      .rsp_total_time     (rsp_total_time),
      .rsp_average_time   (rsp_average_time),
      .rsp_worst_time     (rsp_worst_time),
      .rsp_best_time      (rsp_best_time),
      .rsp_last_time      (rsp_last_time),
      .rsp_total_overflow (rsp_total_overflow)
   );

   always begin
      clock = 1'b1;
      #5;
      clock = 1'b0;
      #5;
   end

   // The receiver decides its stall once per cycle. A hold-off overrides the random draw.
   always @(posedge clock) begin
      rsp_stall <= hold_off || ($urandom_range(99) < rsp_stall_pct);
   end

   // Both monitors sample at the rising edge, so they see the values that the block saw
   // when it decided whether an item moved. Results are checked before the new input
   // item is noted; the two can never belong to the same item.
   always @(posedge clock) begin
      latency_stats_type got;
      if (!reset) begin
         if (rsp_valid && !rsp_stall) begin
            got.sample_count   = rsp_sample_count;
            got.total_time     = rsp_total_time;
            got.average_time   = rsp_average_time;
            got.worst_time     = rsp_worst_time;
            got.best_time      = rsp_best_time;
            got.last_time      = rsp_last_time;
            got.total_overflow = rsp_total_overflow;
            stats_board.check_result(got);
         end
         if (req_valid && !req_stall) begin
            stats_board.note_item(req_operation, req_begin_stamp, req_end_stamp);
         end
      end
   end

   // Offers one input item and returns at the edge where it is accepted. Before the item
   // the sender may go idle for a random gap, which can land on any cycle of the block's
   // work; the payload carries junk while valid is low.
   task send_item(input logic op, input logic [31:0] start_t, input logic [31:0] stop_t);
      int gap;
      if (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
         gap = $urandom_range(1, 80);
         req_valid       <= 1'b0;
         req_operation   <= 1'($urandom_range(1));
         req_begin_stamp <= $urandom;
         req_end_stamp   <= $urandom;
         repeat (gap) @(posedge clock);
      end
      req_valid       <= 1'b1;
      req_operation   <= op;
      req_begin_stamp <= start_t;
      req_end_stamp   <= stop_t;
      do @(posedge clock); while (req_stall);
      items_sent++;
   endtask

   task send_sample(input logic [31:0] start_t, input logic [31:0] duration);
      send_item(RLS_OP_ADD, start_t, start_t + duration);
   endtask

   // Durations are spread over a few bands: short ones keep the average meaningful,
   // huge ones drive the total to wrap and raise the overflow flag.
   function logic [31:0] pick_duration();
      case ($urandom_range(9))
         0, 1, 2: return $urandom_range(0, 1000);
         3, 4:    return $urandom_range(0, 32'h000F_FFFF);
         5, 6:    return $urandom;
         7:       return 32'hFFFF_FFFF - $urandom_range(0, 16);
         8:       return $urandom_range(0, 3);
         default: return {1'($urandom_range(1)), 31'b0} | ($urandom & 32'h7FFF_FFFF);
      endcase
   endfunction

   // Directed items: extreme durations, timer wrap, exact and carrying wraps of the
   // total, repeated clears and a clear straight after reset.
   task run_directed();
      send_item(RLS_OP_CLEAR, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
      send_item(RLS_OP_ADD, 32'h0000_0000, 32'h0000_0000);
      send_item(RLS_OP_ADD, 32'h0000_0000, 32'hFFFF_FFFF);
      send_item(RLS_OP_ADD, 32'hFFFF_FFFF, 32'h0000_0000);
      send_item(RLS_OP_ADD, 32'hFFFF_FFF0, 32'h0000_0010);
      send_item(RLS_OP_CLEAR, 32'h0000_0000, 32'h0000_0000);
      send_item(RLS_OP_ADD, 32'h0000_0005, 32'h0000_0005);
      send_item(RLS_OP_ADD, 32'h0000_0001, 32'h0000_0000);
      send_item(RLS_OP_ADD, 32'hAAAA_AAAA, 32'h5555_5555);
      send_item(RLS_OP_CLEAR, 32'h1234_5678, 32'h8765_4321);
      send_item(RLS_OP_CLEAR, 32'hFFFF_FFFF, 32'h0000_0000);
      send_item(RLS_OP_ADD, 32'h0000_0000, 32'h8000_0000);
      send_item(RLS_OP_ADD, 32'h8000_0000, 32'h0000_0000);
      send_item(RLS_OP_ADD, 32'h5555_5555, 32'hAAAA_AAAA);
      send_item(RLS_OP_ADD, 32'h7FFF_FFFF, 32'h8000_0000);
      send_item(RLS_OP_CLEAR, 32'h0000_0000, 32'hFFFF_FFFF);
      send_item(RLS_OP_ADD, 32'hDEAD_BEEF, 32'hDEAD_BEEF);
      send_item(RLS_OP_ADD, 32'h0000_0003, 32'h0000_000A);
      send_item(RLS_OP_ADD, 32'h0000_0000, 32'h0000_0001);
      send_item(RLS_OP_ADD, 32'hFFFF_FFFE, 32'hFFFF_FFFF);
   endtask

   // Random items: mostly samples, with an occasional clear so that both short and long
   // runs of accumulated statistics occur.
   task run_random(input int count);
      for (int i = 0; i < count; i++) begin
         if ($urandom_range(99) < 4) send_item(RLS_OP_CLEAR, $urandom, $urandom);
         else send_sample($urandom, pick_duration());
      end
   endtask

   // Long receiver hold-off in its own process; the sender keeps offering meanwhile, so
   // the result register fills, the block finishes its next item and stalls its input.
   task start_hold_off(input int cycles);
      fork
         begin
            hold_off = 1'b1;
            repeat (cycles) @(posedge clock);
            hold_off = 1'b0;
         end
      join_none
   endtask

   initial begin
      stats_board = new();
      send_idle_pct = 0;
      rsp_stall_pct = 0;
      hold_off = 1'b0;
      items_sent = 0;
      reset           <= 1'b1;
      req_valid       <= 1'b0;
      req_operation   <= RLS_OP_ADD;
      req_begin_stamp <= '0;
      req_end_stamp   <= '0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      run_directed();

      // Phase with no idling at all; the hold-off lands here while the sender is eager.
      start_hold_off(400);
      run_random(320);
      // Sender idles often, receiver always ready.
      send_idle_pct = 54;
      rsp_stall_pct = 0;
      run_random(320);
      // Receiver stalls often, sender always ready.
      send_idle_pct = 0;
      rsp_stall_pct = 54;
      run_random(320);
      // Light idling on both sides.
      send_idle_pct = 12;
      rsp_stall_pct = 12;
      run_random(320);

      req_valid <= 1'b0;
      // One more edge so that the last accepted item is surely noted before waiting.
      @(posedge clock);
      while (stats_board.pending() > 0) @(posedge clock);
      // Let any stray result surface before the verdict.
      repeat (RLS_TIME_BITS + 8) @(posedge clock);

      $display("Sent %0d items, %0d of them clears; checked %0d result items.",
               items_sent, stats_board.clears_seen, stats_board.results_checked);
      $display("%0d results carried a wrapped total; %0d mismatches found.",
               stats_board.overflow_results, stats_board.errors);
      if (stats_board.errors == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

   // Watchdog: far beyond the slowest correct run of this stimulus.
   initial begin
      #5_000_000;
      $display("Run did not complete in time.");
      $display("status: fail");
      $finish;
   end

endmodule
